// ===== hw/rtl/fom_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, ascii codes, message struct and digit helpers for the fix order encoder
package fom_pkg;

  localparam int DataW    = 32;
  localparam int BcdDigs  = 10;
  localparam int BcdW     = 4 * BcdDigs;
  localparam int CntW     = 4;

  localparam logic [7:0] ChSoh   = 8'h01;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChEq    = 8'h3d;

  typedef struct packed {
    logic                neg;
    logic [BcdW-1:0]     pbcd;
    logic [CntW-1:0]     pcnt;
    logic [BcdW-1:0]     qbcd;
    logic [CntW-1:0]     qcnt;
  } fom_msg_t;

  // number of significant decimal digits, at least one
  function automatic logic [CntW-1:0] digit_count(input logic [BcdW-1:0] bcd);
    logic [CntW-1:0] cnt;
    cnt = CntW'(1);
    for (int i = 0; i < BcdDigs; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        cnt = CntW'(i + 1);
      end
    end
    return cnt;
  endfunction

  // three decimal digits of an 8 bit value, hundreds in the top nibble
  function automatic logic [11:0] dec3(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] r;
    logic [7:0] o;
    h = 4'd0;
    r = v;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = v - 8'd100;
    end
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) begin
        t = 4'(k);
      end
    end
    o = r - (({4'd0, t} << 3) + ({4'd0, t} << 1));
    return {h, t, o[3:0]};
  endfunction

endpackage

// ===== hw/rtl/fix_order_message_encoder.sv =====
`timescale 1ns / 1ps
// top level of the fix 4.2 new order single encoder
//
// in channel: one word per order, in_price (signed ticks) and in_quantity,
// taken when in_valid and in_ready are both high.
// out channel: the message text, one byte per word on out_byte_value,
// out_last_byte high on the closing soh of each message.
// a message is 38 to 57 words long.
// after an order is taken the shared bcd converter runs twice, first on the
// price magnitude and then on the quantity; the first byte leaves once both
// are done and the sequencer is free, and the rest follow one per cycle while the receiver keeps up.
// in_ready returns once both conversions are handed to the byte sequencer;
// the next conversion overlaps the draining of the previous message.
// when the receiver stalls the output register holds its word and the
// sequencer waits; a new message starts only once the last byte is loaded.
// synchronous reset clears all control state; nothing is emitted until the
// next order arrives.
module fix_order_message_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [fom_pkg::DataW-1:0] in_price,
  input  logic [fom_pkg::DataW-1:0]        in_quantity,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte_value,
  output logic                            out_last_byte
);

  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_CONVP  = 2'd1;
  localparam logic [1:0] T_CONVQ  = 2'd2;
  localparam logic [1:0] T_LAUNCH = 2'd3;

  logic [1:0]                st_r, st_nxt;
  logic                      neg_r;
  logic [fom_pkg::DataW-1:0] qty_r;
  logic [fom_pkg::BcdW-1:0]  pbcd_r;
  logic [fom_pkg::CntW-1:0]  pcnt_r;
  logic [fom_pkg::BcdW-1:0]  qbcd_r;
  logic [fom_pkg::CntW-1:0]  qcnt_r;
  logic                      accept;
  logic [fom_pkg::DataW-1:0] pmag;
  logic                      cv_start;
  logic [fom_pkg::DataW-1:0] cv_din;
  logic                      cv_done;
  logic [fom_pkg::BcdW-1:0]  cv_bcd;
  logic                      em_start;
  logic                      em_busy;
  fom_pkg::fom_msg_t         msg;

  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == T_IDLE);
  assign pmag     = in_price[fom_pkg::DataW-1] ? (fom_pkg::DataW'(0) - in_price) : in_price;
  assign cv_start = accept || ((st_r == T_CONVP) && cv_done);
  assign cv_din   = accept ? pmag : qty_r;
  assign em_start = (st_r == T_LAUNCH) && !em_busy;

  assign msg.neg  = neg_r;
  assign msg.pbcd = pbcd_r;
  assign msg.pcnt = pcnt_r;
  assign msg.qbcd = qbcd_r;
  assign msg.qcnt = qcnt_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:   if (accept) st_nxt = T_CONVP;
      T_CONVP:  if (cv_done) st_nxt = T_CONVQ;
      T_CONVQ:  if (cv_done) st_nxt = T_LAUNCH;
      T_LAUNCH: if (!em_busy) st_nxt = T_IDLE;
      default:  st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_price[fom_pkg::DataW-1];
      qty_r <= in_quantity;
    end
    if ((st_r == T_CONVP) && cv_done) begin
      pbcd_r <= cv_bcd;
      pcnt_r <= fom_pkg::digit_count(cv_bcd);
    end
    if ((st_r == T_CONVQ) && cv_done) begin
      qbcd_r <= cv_bcd;
      qcnt_r <= fom_pkg::digit_count(cv_bcd);
    end
  end

  fom_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cv_start),
    .din   (cv_din),
    .done  (cv_done),
    .bcd   (cv_bcd)
  );

  fom_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (em_start),
    .msg            (msg),
    .busy           (em_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_value (out_byte_value),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ===== hw/rtl/fom_bcd.sv =====
`timescale 1ns / 1ps
// shared shift-and-add-3 binary to bcd converter, one bit per cycle
module fom_bcd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [fom_pkg::DataW-1:0] din,
  output logic                     done,
  output logic [fom_pkg::BcdW-1:0]  bcd
);

  localparam int StepW = $clog2(fom_pkg::DataW);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [StepW-1:0]          cnt_r, cnt_nxt;
  logic [fom_pkg::DataW-1:0] sh_r, sh_nxt;
  logic [fom_pkg::BcdW-1:0]  bcd_r, bcd_nxt;
  logic [fom_pkg::BcdW-1:0]  adj;

  always_comb begin
    for (int i = 0; i < fom_pkg::BcdDigs; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      sh_nxt  = din;
      bcd_nxt = '0;
    end else if (run_r) begin
      bcd_nxt = {adj[fom_pkg::BcdW-2:0], sh_r[fom_pkg::DataW-1]};
      sh_nxt  = {sh_r[fom_pkg::DataW-2:0], 1'b0};
      cnt_nxt = cnt_r + StepW'(1);
      if (cnt_r == StepW'(fom_pkg::DataW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ===== hw/rtl/fom_emit.sv =====
`timescale 1ns / 1ps
// byte sequencer that writes the message text, length and checksum into the output register
module fom_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fom_pkg::fom_msg_t msg,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte_value,
  output logic              out_last_byte
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_PRE  = 3'd1;
  localparam logic [2:0] E_NEG  = 3'd2;
  localparam logic [2:0] E_PDIG = 3'd3;
  localparam logic [2:0] E_MID  = 3'd4;
  localparam logic [2:0] E_QDIG = 3'd5;
  localparam logic [2:0] E_TAIL = 3'd6;
  localparam logic [2:0] E_CK   = 3'd7;

  localparam logic [4:0] PreLast   = 5'd23;
  localparam logic [4:0] GroupLast = 5'd3;

  logic [2:0]        st_r, st_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  fom_pkg::fom_msg_t msg_r;
  logic [5:0]        blen_r;
  logic              adv;
  logic              acc;
  logic [7:0]        cur_byte;
  logic [11:0]       blen_dig;
  logic [11:0]       sum_dig;
  logic [4:0]        pfirst;
  logic [4:0]        qfirst;

  // constant prefix up to "44=", with the two live body length digits
  function automatic logic [7:0] pre_byte(input logic [4:0] i, input logic [3:0] t,
                                          input logic [3:0] o);
    logic [7:0] b;
    unique case (i)
      5'd0:    b = 8'h38;
      5'd1:    b = fom_pkg::ChEq;
      5'd2:    b = 8'h46;
      5'd3:    b = 8'h49;
      5'd4:    b = 8'h58;
      5'd5:    b = 8'h2e;
      5'd6:    b = 8'h34;
      5'd7:    b = 8'h2e;
      5'd8:    b = 8'h32;
      5'd9:    b = fom_pkg::ChSoh;
      5'd10:   b = 8'h39;
      5'd11:   b = fom_pkg::ChEq;
      5'd12:   b = fom_pkg::ChZero;
      5'd13:   b = fom_pkg::ChZero + {4'd0, t};
      5'd14:   b = fom_pkg::ChZero + {4'd0, o};
      5'd15:   b = fom_pkg::ChSoh;
      5'd16:   b = 8'h33;
      5'd17:   b = 8'h35;
      5'd18:   b = fom_pkg::ChEq;
      5'd19:   b = 8'h44;
      5'd20:   b = fom_pkg::ChSoh;
      5'd21:   b = 8'h34;
      5'd22:   b = 8'h34;
      5'd23:   b = fom_pkg::ChEq;
      default: b = fom_pkg::ChSoh;
    endcase
    return b;
  endfunction

  assign blen_dig = fom_pkg::dec3({2'b00, blen_r});
  assign sum_dig  = fom_pkg::dec3(sum_r);
  assign pfirst   = {1'b0, msg_r.pcnt - 4'd1};
  assign qfirst   = {1'b0, msg_r.qcnt - 4'd1};
  assign adv      = (st_r != E_IDLE) && (!out_valid_r || out_ready);
  assign acc      = (st_r != E_CK) && !((st_r == E_TAIL) && (idx_r != 5'd0));

  always_comb begin
    cur_byte = fom_pkg::ChSoh;
    unique case (st_r)
      E_IDLE: cur_byte = fom_pkg::ChSoh;
      E_PRE:  cur_byte = pre_byte(idx_r, blen_dig[7:4], blen_dig[3:0]);
      E_NEG:  cur_byte = fom_pkg::ChMinus;
      E_PDIG: cur_byte = fom_pkg::ChZero + {4'd0, msg_r.pbcd[4*idx_r[3:0] +: 4]};
      E_MID: begin
        unique case (idx_r[1:0])
          2'd0:    cur_byte = fom_pkg::ChSoh;
          2'd1:    cur_byte = 8'h33;
          2'd2:    cur_byte = 8'h38;
          default: cur_byte = fom_pkg::ChEq;
        endcase
      end
      E_QDIG: cur_byte = fom_pkg::ChZero + {4'd0, msg_r.qbcd[4*idx_r[3:0] +: 4]};
      E_TAIL: begin
        unique case (idx_r[1:0])
          2'd0:    cur_byte = fom_pkg::ChSoh;
          2'd1:    cur_byte = 8'h31;
          2'd2:    cur_byte = fom_pkg::ChZero;
          default: cur_byte = fom_pkg::ChEq;
        endcase
      end
      E_CK: begin
        unique case (idx_r[1:0])
          2'd0:    cur_byte = fom_pkg::ChZero + {4'd0, sum_dig[11:8]};
          2'd1:    cur_byte = fom_pkg::ChZero + {4'd0, sum_dig[7:4]};
          2'd2:    cur_byte = fom_pkg::ChZero + {4'd0, sum_dig[3:0]};
          default: cur_byte = fom_pkg::ChSoh;
        endcase
      end
      default: cur_byte = fom_pkg::ChSoh;
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    unique case (st_r)
      E_IDLE: begin
        if (start) begin
          st_nxt  = E_PRE;
          idx_nxt = '0;
          sum_nxt = '0;
        end
      end
      E_PRE: begin
        if (adv) begin
          if (idx_r == PreLast) begin
            st_nxt  = msg_r.neg ? E_NEG : E_PDIG;
            idx_nxt = pfirst;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      E_NEG: begin
        if (adv) begin
          st_nxt = E_PDIG;
        end
      end
      E_PDIG: begin
        if (adv) begin
          if (idx_r == 5'd0) begin
            st_nxt = E_MID;
          end else begin
            idx_nxt = idx_r - 5'd1;
          end
        end
      end
      E_MID: begin
        if (adv) begin
          if (idx_r == GroupLast) begin
            st_nxt  = E_QDIG;
            idx_nxt = qfirst;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      E_QDIG: begin
        if (adv) begin
          if (idx_r == 5'd0) begin
            st_nxt = E_TAIL;
          end else begin
            idx_nxt = idx_r - 5'd1;
          end
        end
      end
      E_TAIL: begin
        if (adv) begin
          if (idx_r == GroupLast) begin
            st_nxt  = E_CK;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      E_CK: begin
        if (adv) begin
          if (idx_r == GroupLast) begin
            st_nxt = E_IDLE;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      default: st_nxt = E_IDLE;
    endcase
    if (adv && acc) begin
      sum_nxt = sum_r + cur_byte;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    if ((st_r == E_IDLE) && start) begin
      msg_r  <= msg;
      blen_r <= 6'd13 + {5'd0, msg.neg} + {2'd0, msg.pcnt} + {2'd0, msg.qcnt};
    end
    if (adv) begin
      out_byte_r <= cur_byte;
      out_last_r <= (st_r == E_CK) && (idx_r == GroupLast);
    end
  end

  assign busy           = (st_r != E_IDLE);
  assign out_valid      = out_valid_r;
  assign out_byte_value = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule

// ===== hw/rtl/fom_chk.sv =====
`timescale 1ns / 1ps
// port level checker for the fix order encoder and its bind
module fom_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte_value,
  input logic       out_last_byte
);

  logic first_r;

  // high while the next word to leave is the first of a message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= out_last_byte;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_value) && $stable(out_last_byte))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an order was taken");

  a_last_is_soh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte_value == fom_pkg::ChSoh)
    else $error("final word is not soh");

  a_first_is_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> out_byte_value == 8'h38 && !out_last_byte)
    else $error("message does not open with the begin string tag");

endmodule

bind fix_order_message_encoder fom_chk u_fom_chk (.*);
